### sv/srec_pkg.sv
// shared types, constants and helpers of the s-record text encoder
`timescale 1ns / 1ps
`default_nettype none

package srec_pkg;

    localparam int RECORD_BYTES = 16;

    localparam int FILL_W   = $clog2(RECORD_BYTES + 1);
    localparam int IDX_W    = $clog2(RECORD_BYTES + 4);
    localparam int STORE_AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_LOAD_ADDRESS     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BYTES_PER_RECORD = CFG_INDEX_W'(1);

    localparam logic [1:0] FUNC_NAME   = 2'd0;
    localparam logic [1:0] FUNC_DATA   = 2'd1;
    localparam logic [1:0] FUNC_FINISH = 2'd2;

    localparam logic [4:0]  BPR_RESET    = 5'd16;
    localparam logic [7:0]  REC_OVERHEAD = 8'd3;
    localparam logic [15:0] TALLY_MAX    = 16'hFFFF;

    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_1  = 8'h31;
    localparam logic [7:0] CHAR_5  = 8'h35;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_NL = 8'h0A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_S,
        ST_TYPE,
        ST_HI,
        ST_LO,
        ST_NL
    } srec_state_t;

    // uppercase hex digit of one nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h37 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/srecord_ascii_encoder.sv
// s-record text encoder: byte buffer, record sequencer and character output register
//
// Name and data bytes are gathered in a 16-entry byte buffer; data reaching the
// bytes-per-record limit or a beat marked end_of_block produces one record (S0 for
// names, S1 at the running address); a finish beat produces S5 and S9. Text leaves
// one character per cycle, unless m_ready stalls it, from the record sequencer, which
// steps through a byte one hex nibble at a time and folds it into the checksum as it
// goes. Input is taken only while the sequencer is idle; the last character may still
// wait in the output register. Configuration writes are always taken and must only be
// issued while idle.
`timescale 1ns / 1ps
`default_nettype none

module srecord_ascii_encoder
    import srec_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_func,
    input  wire logic [7:0]             s_byte_value,
    input  wire logic                   s_end_of_block,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [7:0]                  m_ascii_char,
    output logic                        m_last_of_run
);

    srec_state_t          state_reg, state_next;

    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic                 header_reg, header_next;
    logic [15:0]          run_addr_reg, run_addr_next;
    logic [15:0]          tally_reg, tally_next;
    logic [15:0]          load_addr_reg, load_addr_next;
    logic [4:0]           bpr_reg, bpr_next;
    logic [7:0]           store_reg [RECORD_BYTES];

    logic [7:0]           rec_type_reg, rec_type_next;
    logic [FILL_W-1:0]    rec_len_reg, rec_len_next;
    logic [15:0]          rec_addr_reg, rec_addr_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [7:0]           sum_reg, sum_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 then_s9_reg, then_s9_next;

    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           m_char_reg, m_char_next;
    logic                 m_last_reg, m_last_next;

    logic                 accept;
    logic                 adv;
    logic [5:0]           bpr_ext;
    logic [FILL_W-1:0]    limit;
    logic                 is_name;
    logic [FILL_W-1:0]    base_fill;
    logic                 room;
    logic [FILL_W-1:0]    new_fill;
    logic                 start_rec;
    logic [IDX_W-1:0]     last_idx;
    logic                 idx_done;
    logic [IDX_W-1:0]     idx_plus;
    logic [IDX_W-1:0]     data_sel;
    logic [7:0]           next_byte;
    logic                 store_we;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign adv       = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_ascii_char  = m_char_reg;
    assign m_last_of_run = m_last_reg;

    // record length limit
    assign bpr_ext = {1'b0, bpr_reg};
    always_comb begin
        if (bpr_ext == 6'd0) begin
            limit = FILL_W'(1);
        end else if (bpr_ext > 6'(RECORD_BYTES)) begin
            limit = FILL_W'(RECORD_BYTES);
        end else begin
            limit = FILL_W'(bpr_ext);
        end
    end

    // buffer fill for the incoming beat
    assign is_name   = (s_func == FUNC_NAME);
    assign base_fill = (is_name != header_reg) ? '0 : fill_reg;
    assign room      = (base_fill < limit);
    assign new_fill  = room ? base_fill + FILL_W'(1) : base_fill;
    assign store_we  = accept && (s_func == FUNC_NAME || s_func == FUNC_DATA) && room;

    assign start_rec = accept && ((s_func == FUNC_FINISH)
                     || (s_func == FUNC_NAME && s_end_of_block)
                     || (s_func == FUNC_DATA && (s_end_of_block || new_fill >= limit)));

    // byte selection for the sequencer
    assign last_idx = IDX_W'(rec_len_reg) + IDX_W'(REC_OVERHEAD);
    assign idx_done = (idx_reg == last_idx);
    assign idx_plus = idx_reg + IDX_W'(1);
    assign data_sel = idx_plus - IDX_W'(REC_OVERHEAD);

    always_comb begin
        if (idx_plus == last_idx) begin
            next_byte = ~(sum_reg + byte_reg);
        end else if (idx_plus == IDX_W'(1)) begin
            next_byte = rec_addr_reg[15:8];
        end else if (idx_plus == IDX_W'(2)) begin
            next_byte = rec_addr_reg[7:0];
        end else begin
            next_byte = store_reg[data_sel[STORE_AW-1:0]];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_rec) begin
                    state_next = ST_S;
                end
            end
            ST_S: begin
                if (adv) begin
                    state_next = ST_TYPE;
                end
            end
            ST_TYPE: begin
                if (adv) begin
                    state_next = ST_HI;
                end
            end
            ST_HI: begin
                if (adv) begin
                    state_next = ST_LO;
                end
            end
            ST_LO: begin
                if (adv) begin
                    state_next = idx_done ? ST_NL : ST_HI;
                end
            end
            ST_NL: begin
                if (adv) begin
                    state_next = then_s9_reg ? ST_S : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        fill_next      = fill_reg;
        header_next    = header_reg;
        run_addr_next  = run_addr_reg;
        tally_next     = tally_reg;
        load_addr_next = load_addr_reg;
        bpr_next       = bpr_reg;
        rec_type_next  = rec_type_reg;
        rec_len_next   = rec_len_reg;
        rec_addr_next  = rec_addr_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        byte_next      = byte_reg;
        then_s9_next   = then_s9_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_char_next    = m_char_reg;
        m_last_next    = m_last_reg;

        if (accept) begin
            case (s_func)
                FUNC_NAME: begin
                    header_next = 1'b1;
                    if (s_end_of_block) begin
                        rec_type_next = CHAR_0;
                        rec_addr_next = 16'h0000;
                        rec_len_next  = new_fill;
                        fill_next     = '0;
                    end else begin
                        fill_next = new_fill;
                    end
                end
                FUNC_DATA: begin
                    header_next = 1'b0;
                    if (s_end_of_block || new_fill >= limit) begin
                        rec_type_next = CHAR_1;
                        rec_addr_next = run_addr_reg;
                        rec_len_next  = new_fill;
                        run_addr_next = run_addr_reg + 16'(new_fill);
                        if (tally_reg != TALLY_MAX) begin
                            tally_next = tally_reg + 16'd1;
                        end
                        fill_next = '0;
                    end else begin
                        fill_next = new_fill;
                    end
                end
                FUNC_FINISH: begin
                    rec_type_next = CHAR_5;
                    rec_addr_next = tally_reg;
                    rec_len_next  = '0;
                    then_s9_next  = 1'b1;
                    fill_next     = '0;
                    header_next   = 1'b0;
                    run_addr_next = load_addr_reg;
                    tally_next    = '0;
                end
                default: begin
                end
            endcase
            idx_next  = '0;
            sum_next  = '0;
            byte_next = 8'(rec_len_next) + REC_OVERHEAD;
        end

        if (adv) begin
            case (state_reg)
                ST_S: begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_S;
                    m_last_next  = 1'b0;
                end
                ST_TYPE: begin
                    m_valid_next = 1'b1;
                    m_char_next  = rec_type_reg;
                    m_last_next  = 1'b0;
                end
                ST_HI: begin
                    m_valid_next = 1'b1;
                    m_char_next  = hex_char(byte_reg[7:4]);
                    m_last_next  = 1'b0;
                end
                ST_LO: begin
                    m_valid_next = 1'b1;
                    m_char_next  = hex_char(byte_reg[3:0]);
                    m_last_next  = 1'b0;
                    sum_next     = sum_reg + byte_reg;
                    idx_next     = idx_plus;
                    byte_next    = next_byte;
                end
                ST_NL: begin
                    m_valid_next = 1'b1;
                    m_char_next  = CHAR_NL;
                    m_last_next  = !then_s9_reg;
                    if (then_s9_reg) begin
                        then_s9_next  = 1'b0;
                        rec_type_next = CHAR_9;
                        rec_addr_next = 16'h0000;
                        rec_len_next  = '0;
                        idx_next      = '0;
                        sum_next      = '0;
                        byte_next     = REC_OVERHEAD;
                    end
                end
                default: begin
                end
            endcase
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_LOAD_ADDRESS: begin
                    load_addr_next = cfg_data[15:0];
                    run_addr_next  = cfg_data[15:0];
                end
                REG_BYTES_PER_RECORD: begin
                    bpr_next = cfg_data[4:0];
                end
                default: begin
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            header_reg    <= 1'b0;
            run_addr_reg  <= '0;
            tally_reg     <= '0;
            load_addr_reg <= '0;
            bpr_reg       <= BPR_RESET;
            then_s9_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            header_reg    <= header_next;
            run_addr_reg  <= run_addr_next;
            tally_reg     <= tally_next;
            load_addr_reg <= load_addr_next;
            bpr_reg       <= bpr_next;
            then_s9_reg   <= then_s9_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rec_type_reg <= rec_type_next;
        rec_len_reg  <= rec_len_next;
        rec_addr_reg <= rec_addr_next;
        idx_reg      <= idx_next;
        sum_reg      <= sum_next;
        byte_reg     <= byte_next;
        m_char_reg   <= m_char_next;
        m_last_reg   <= m_last_next;
        if (store_we) begin
            store_reg[base_fill[STORE_AW-1:0]] <= s_byte_value;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(RECORD_BYTES))
        else $error("buffer fill beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HI || state_reg == ST_LO) |-> (idx_reg <= last_idx))
        else $error("byte index past checksum");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func == FUNC_FINISH) |=> then_s9_reg)
        else $error("finish did not queue closing record");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (start_rec) |=> (state_reg == ST_S && idx_reg == '0 && sum_reg == 8'h00))
        else $error("record start not set up");

endmodule

`default_nettype wire
